// ===== hw/rtl/etpm_pkg.sv =====
// ----------------------------------------------------------------------------
// etpm_pkg
// Shared types, constants and helper functions for the escape-time palette
// mapper: register indexes, palette codes, fixed-point constants and sine math.
// ----------------------------------------------------------------------------
package etpm_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] REG_ITERATION_LIMIT = 8'd0;
    localparam logic [7:0] REG_PALETTE_SELECT  = 8'd1;

    // palette codes
    localparam logic [1:0] PAL_CLASSIC = 2'd0;
    localparam logic [1:0] PAL_FIRE    = 2'd1;
    localparam logic [1:0] PAL_ICE     = 2'd2;
    localparam logic [1:0] PAL_GRAY    = 2'd3;

    localparam logic [15:0] LIMIT_RESET   = 16'd256;
    localparam logic [1:0]  PALETTE_RESET = PAL_CLASSIC;

    // defaults for the top-level parameters
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int SINE_ENTRIES_DEFAULT  = 1024;

    // t is unsigned Q0.16; the divider resolves this many quotient bits a stage
    localparam int T_BITS         = 16;
    localparam int DIV_BITS_STAGE = 2;
    localparam int DIV_STAGES     = T_BITS / DIV_BITS_STAGE;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // odd polynomial for sin(pi/2 * x), Q2.30
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598668;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    // classic palette phases in Q0.16 turns
    localparam logic [15:0] PHASE [3] = '{16'd0, 16'd21627, 16'd43909};

    // fire and ice coefficients in Q0.16
    localparam logic [15:0] K_035 = 16'd22938;
    localparam logic [15:0] K_030 = 16'd19661;
    localparam logic [15:0] K_045 = 16'd29491;
    localparam logic [15:0] K_055 = 16'd36045;
    localparam logic [15:0] K_065 = 16'd42598;

    typedef logic [16:0] chan_t;

    typedef struct packed {
        logic black;
        logic zero;
    } flags_t;

    // rounded quarter-wave sine magnitude in Q1.16, x in Q0.30
    function automatic chan_t sine_mag(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] m;
        x2 = (x * x) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((x2 * p) >> 30);
        p  = SIN_C5 - ((x2 * p) >> 30);
        p  = SIN_C3 - ((x2 * p) >> 30);
        p  = SIN_C1 - ((x2 * p) >> 30);
        p  = (x * p) >> 30;
        if (p > ONE_Q30)
        begin
            p = ONE_Q30;
        end
        m = (p + 64'd8192) >> 14;
        if (m > 64'd65536)
        begin
            m = 64'd65536;
        end
        return m[16:0];
    endfunction

    function automatic chan_t clamp_one(input logic [17:0] v);
        return (v > 18'(ONE_Q16)) ? ONE_Q16 : v[16:0];
    endfunction

    // 255 * c / 65536, round half up
    function automatic logic [7:0] to_byte(input chan_t c);
        logic [24:0] s;
        s = 25'(c) * 25'd255 + 25'd32768;
        return s[23:16];
    endfunction

endpackage

// ===== hw/rtl/etpm_div.sv =====
// ----------------------------------------------------------------------------
// etpm_div
// Limit compare and pipelined restoring divider: t = x / (limit << FB) in Q0.16,
// a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module etpm_div #(
    parameter int FRACTION_BITS = etpm_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    value,
    input  logic [15:0]           limit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           t,
    output etpm_pkg::flags_t      flags
);

    localparam int DW  = etpm_pkg::T_BITS + FRACTION_BITS;
    localparam int RW  = DW + 1;
    localparam int CW  = (DW + 2 > 33) ? DW + 2 : 33;
    localparam int NS  = etpm_pkg::DIV_STAGES;
    localparam int BPS = etpm_pkg::DIV_BITS_STAGE;

    logic [DW-1:0]           divisor;
    logic signed [CW-1:0]    x_ext;
    logic signed [CW-1:0]    d_ext;
    etpm_pkg::flags_t        fl_entry;
    logic [RW-1:0]           rem_entry;

    logic [RW-1:0]           rem_reg [NS+1];
    logic [15:0]             q_reg   [NS+1];
    etpm_pkg::flags_t        fl_reg  [NS+1];
    logic [NS:0]             v_reg;
    logic [NS+1:0]           en;

    assign divisor = {limit, FRACTION_BITS'(0)};
    assign x_ext   = CW'(value);
    assign d_ext   = $signed(CW'(divisor));

    always_comb
    begin
        fl_entry.black = (x_ext >= d_ext);
        fl_entry.zero  = value[31] || (value == 32'sd0);
        rem_entry      = fl_entry.zero ? '0 : RW'(value[30:0]);
    end

    assign en[NS+1]  = out_ready;
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS];
    assign t         = fl_reg[NS].zero ? 16'd0 : q_reg[NS];
    assign flags     = fl_reg[NS];

    // entry stage
    assign en[0] = !v_reg[0] || en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= rem_entry;
            q_reg[0]   <= '0;
            fl_reg[0]  <= fl_entry;
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        logic [RW-1:0] rem_next;
        logic [15:0]   q_next;

        assign en[k] = !v_reg[k] || en[k+1];

        always_comb
        begin
            logic [RW-1:0] r;
            logic [RW-1:0] r2;
            logic [15:0]   q;
            r = rem_reg[k-1];
            q = q_reg[k-1];
            for (int b = 0; b < BPS; b++)
            begin
                r2 = {r[RW-2:0], 1'b0};
                if (r2 >= RW'(divisor))
                begin
                    r = r2 - RW'(divisor);
                    q = {q[14:0], 1'b1};
                end
                else
                begin
                    r = r2;
                    q = {q[14:0], 1'b0};
                end
            end
            rem_next = r;
            q_next   = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                fl_reg[k]  <= fl_reg[k-1];
            end
        end
    end

endmodule

// ===== hw/rtl/etpm_pal.sv =====
// ----------------------------------------------------------------------------
// etpm_pal
// Three-stage palette unit: sine table lookups, fire polynomials, ice ramps
// and grayscale, then palette selection into Q1.16 channels.
// ----------------------------------------------------------------------------
module etpm_pal #(
    parameter int SINE_ENTRIES = etpm_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       t,
    input  etpm_pkg::flags_t  flags,
    input  logic [1:0]        palette,
    output logic              out_valid,
    input  logic              out_ready,
    output etpm_pkg::chan_t   red_c,
    output etpm_pkg::chan_t   green_c,
    output etpm_pkg::chan_t   blue_c,
    output logic              black
);

    localparam int QN = SINE_ENTRIES / 4;
    localparam int IW = $clog2(SINE_ENTRIES);
    localparam int JW = $clog2(QN);
    localparam logic [IW-1:0] Q1 = IW'(QN);
    localparam logic [IW-1:0] Q2 = IW'(2 * QN);
    localparam logic [IW-1:0] Q3 = IW'(3 * QN);

    // quarter tables: one for rising quadrants, one for falling ones
    etpm_pkg::chan_t rom_even [QN];
    etpm_pkg::chan_t rom_odd  [QN];

    for (genvar g = 0; g < QN; g++)
    begin : g_rom
        localparam logic [63:0] F = (64'(g) << 30) / 64'(QN);
        assign rom_even[g] = etpm_pkg::sine_mag(F);
        assign rom_odd[g]  = etpm_pkg::sine_mag(etpm_pkg::ONE_Q30 - F);
    end

    logic [3:0] en;
    logic [2:0] v_reg;

    assign en[3]     = out_ready;
    assign en[2]     = !v_reg[2] || en[3];
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // stage 1: sine lookups, t squared, ice ramps
    etpm_pkg::chan_t  cls_next [3];
    etpm_pkg::chan_t  ice_next [3];
    logic [31:0]      sq;
    logic [31:0]      ice_p [3];

    always_comb
    begin
        logic [15:0]      ang;
        logic [16+IW-1:0] prod;
        logic [IW-1:0]    idx;
        logic [IW-1:0]    j;
        logic             odd;
        logic             neg;
        etpm_pkg::chan_t  m;
        logic [17:0]      s;
        for (int c = 0; c < 3; c++)
        begin
            ang  = t + etpm_pkg::PHASE[c];
            prod = (16+IW)'(ang) * (16+IW)'(SINE_ENTRIES);
            idx  = prod[16+IW-1:16];
            if (idx >= Q3)
            begin
                j = idx - Q3; odd = 1'b1; neg = 1'b1;
            end
            else if (idx >= Q2)
            begin
                j = idx - Q2; odd = 1'b0; neg = 1'b1;
            end
            else if (idx >= Q1)
            begin
                j = idx - Q1; odd = 1'b1; neg = 1'b0;
            end
            else
            begin
                j = idx; odd = 1'b0; neg = 1'b0;
            end
            m = odd ? rom_odd[j[JW-1:0]] : rom_even[j[JW-1:0]];
            s = neg ? 18'(etpm_pkg::ONE_Q16) - 18'(m) : 18'(etpm_pkg::ONE_Q16) + 18'(m);
            cls_next[c] = s[17:1];
        end
        sq       = 32'(t) * 32'(t);
        ice_p[0] = 32'(t) * 32'(etpm_pkg::K_030);
        ice_p[1] = 32'(t) * 32'(etpm_pkg::K_045);
        ice_p[2] = 32'(t) * 32'(etpm_pkg::K_035);
        ice_next[0] = etpm_pkg::clamp_one(18'(ice_p[0][31:16]));
        ice_next[1] = etpm_pkg::clamp_one(18'(etpm_pkg::K_055) + 18'(ice_p[1][31:16]));
        ice_next[2] = etpm_pkg::clamp_one(18'(etpm_pkg::K_065) + 18'(ice_p[2][31:16]));
    end

    logic [15:0]       t1_reg;
    logic [15:0]       t2_1_reg;
    etpm_pkg::chan_t   cls1_reg [3];
    etpm_pkg::chan_t   ice1_reg [3];
    etpm_pkg::flags_t  fl1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg   <= t;
            t2_1_reg <= sq[31:16];
            cls1_reg <= cls_next;
            ice1_reg <= ice_next;
            fl1_reg  <= flags;
        end
    end

    // stage 2: t cubed, fire red and green
    logic [31:0] cube;
    logic [17:0] fire_r3;
    logic [17:0] fire_g3;

    assign cube    = 32'(t2_1_reg) * 32'(t1_reg);
    assign fire_r3 = 18'(t1_reg) * 18'd3;
    assign fire_g3 = 18'(t2_1_reg) * 18'd3;

    logic [15:0]       t2_reg;
    logic [15:0]       t3_2_reg;
    etpm_pkg::chan_t   fire_r2_reg;
    etpm_pkg::chan_t   fire_g2_reg;
    etpm_pkg::chan_t   cls2_reg [3];
    etpm_pkg::chan_t   ice2_reg [3];
    etpm_pkg::flags_t  fl2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t2_reg      <= t1_reg;
            t3_2_reg    <= cube[31:16];
            fire_r2_reg <= etpm_pkg::clamp_one({1'b0, fire_r3[17:1]});
            fire_g2_reg <= etpm_pkg::clamp_one({1'b0, fire_g3[17:1]});
            cls2_reg    <= cls1_reg;
            ice2_reg    <= ice1_reg;
            fl2_reg     <= fl1_reg;
        end
    end

    // stage 3: fire blue and palette selection
    logic [31:0]      fire_bp;
    etpm_pkg::chan_t  sel_next [3];

    assign fire_bp = 32'(t3_2_reg) * 32'(etpm_pkg::K_035);

    always_comb
    begin
        case (palette)
            etpm_pkg::PAL_CLASSIC:
            begin
                sel_next = cls2_reg;
            end
            etpm_pkg::PAL_FIRE:
            begin
                sel_next[0] = fire_r2_reg;
                sel_next[1] = fire_g2_reg;
                sel_next[2] = etpm_pkg::clamp_one(18'(fire_bp[31:16]));
            end
            etpm_pkg::PAL_ICE:
            begin
                sel_next = ice2_reg;
            end
            default:
            begin
                sel_next[0] = 17'(t2_reg);
                sel_next[1] = 17'(t2_reg);
                sel_next[2] = 17'(t2_reg);
            end
        endcase
    end

    etpm_pkg::chan_t sel3_reg [3];
    logic            black3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sel3_reg   <= sel_next;
            black3_reg <= fl2_reg.black;
        end
    end

    assign red_c   = sel3_reg[0];
    assign green_c = sel3_reg[1];
    assign blue_c  = sel3_reg[2];
    assign black   = black3_reg;

endmodule

// ===== hw/rtl/escape_time_palette_mapper.sv =====
// ----------------------------------------------------------------------------
// escape_time_palette_mapper
// Maps one smooth escape-time value per pixel to an 8-bit RGB colour.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready carry iteration_value, signed fixed point.
//   out channel : out_valid/out_ready carry red, green, blue.
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//                 iteration_limit, index 1 palette_select, others are ignored.
//                 cfg_ready is always high; write only while the pipe is empty.
// The pipe holds a limit compare stage, 8 divider stages of 2 quotient bits
// each, 3 palette stages and the byte scaling register. One pixel is taken
// every cycle while the output is not stalled; the rate is set by the
// pipelined divider and palette multipliers, each stage holding one item.
// Reset empties the pipe and sets the limit to 256 and the classic palette.
// When the receiver stalls, stages fill up behind the output register; empty
// stages keep taking requests until the whole pipe is full, and nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module escape_time_palette_mapper #(
    parameter int FRACTION_BITS = etpm_pkg::FRACTION_BITS_DEFAULT,
    parameter int SINE_ENTRIES  = etpm_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] iteration_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    logic [15:0] limit_reg;
    logic [1:0]  palette_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= etpm_pkg::LIMIT_RESET;
            palette_reg <= etpm_pkg::PALETTE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                etpm_pkg::REG_ITERATION_LIMIT:
                begin
                    limit_reg <= cfg_data;
                end
                etpm_pkg::REG_PALETTE_SELECT:
                begin
                    palette_reg <= cfg_data[1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    logic              div_valid;
    logic              div_ready;
    logic [15:0]       div_t;
    etpm_pkg::flags_t  div_flags;

    etpm_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (iteration_value),
        .limit     (limit_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .t         (div_t),
        .flags     (div_flags)
    );

    logic             pal_valid;
    logic             pal_ready;
    etpm_pkg::chan_t  pal_red;
    etpm_pkg::chan_t  pal_green;
    etpm_pkg::chan_t  pal_blue;
    logic             pal_black;

    etpm_pal #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_pal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .t         (div_t),
        .flags     (div_flags),
        .palette   (palette_reg),
        .out_valid (pal_valid),
        .out_ready (pal_ready),
        .red_c     (pal_red),
        .green_c   (pal_green),
        .blue_c    (pal_blue),
        .black     (pal_black)
    );

    // output register: scale to bytes, black overrides the palette
    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    assign pal_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pal_ready)
        begin
            out_valid_reg <= pal_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_ready)
        begin
            red_reg   <= pal_black ? 8'd0 : etpm_pkg::to_byte(pal_red);
            green_reg <= pal_black ? 8'd0 : etpm_pkg::to_byte(pal_green);
            blue_reg  <= pal_black ? 8'd0 : etpm_pkg::to_byte(pal_blue);
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef NO_ASSERTIONS
    // the input side only blocks when the whole pipe backs up from the output
    a_block_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input blocked without an output stall");

    // palette channels never exceed one
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        pal_valid |-> (pal_red <= etpm_pkg::ONE_Q16 && pal_green <= etpm_pkg::ONE_Q16
                       && pal_blue <= etpm_pkg::ONE_Q16))
        else $error("palette channel above one");

    // a black pixel leaves the output register as all zero
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pal_valid && pal_ready && pal_black) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("black pixel not zero");

    // a stalled palette result is held until taken
    a_pal_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pal_valid && !pal_ready) |=> (pal_valid && $stable(pal_red) && $stable(pal_black)))
        else $error("palette result lost under stall");
`endif

endmodule
